@@ rtl/gse_pkg.sv @@
// ----------------------------------------------------------------------------
// gse_pkg
// shared types and constants for the gnome sort engine
// ----------------------------------------------------------------------------
package gse_pkg;

    localparam int DATA_W = 16;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctrl_t;

endpackage

@@ rtl/gse_if.sv @@
// ----------------------------------------------------------------------------
// gse_in_if / gse_out_if
// valid/ready item channels for the element feed and the sorted drain
// ----------------------------------------------------------------------------
interface gse_in_if;
    logic                     valid;
    logic                     ready;
    logic [gse_pkg::DATA_W-1:0] elem_value;
    logic                     is_final;

    modport source (output valid, output elem_value, output is_final, input ready);
    modport sink   (input valid, input elem_value, input is_final, output ready);
endinterface

interface gse_out_if;
    logic                     valid;
    logic                     ready;
    logic [gse_pkg::DATA_W-1:0] sorted_value;
    logic                     last_out;

    modport source (output valid, output sorted_value, output last_out, input ready);
    modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

@@ rtl/gse_cell.sv @@
// ----------------------------------------------------------------------------
// gse_cell
// one slot of the sorted row: takes the new element, shifts right to make
// room, or shifts left while draining
// ----------------------------------------------------------------------------
module gse_cell #(
    parameter int W = 16
) (
    input  logic                clk,
    input  gse_pkg::cell_ctrl_t ctrl,
    input  logic [W-1:0]        new_val,
    input  logic                occ_self,
    input  logic                left_less,
    input  logic [W-1:0]        left_val,
    input  logic [W-1:0]        right_val,
    output logic                less,
    output logic [W-1:0]        val
);

    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;

    assign less = !occ_self || (new_val < val_reg);
    assign val  = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.shift_out)
        begin
            val_next = right_val;
        end
        else if (ctrl.insert)
        begin
            if (left_less)
            begin
                val_next = left_val;
            end
            else if (less)
            begin
                val_next = new_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

@@ rtl/gnome_sort_engine.sv @@
// ----------------------------------------------------------------------------
// gnome_sort_engine
// sorts a set of unsigned elements into ascending order in a row of cells
// load: one item per cycle, each element dropped into place as it arrives
// drain: first sorted item in the cycle after the final item, then one per cycle while drain is ready
// the feed is stalled while draining
// reset clears the fill count and returns to loading; cell contents stay
// ----------------------------------------------------------------------------
module gnome_sort_engine #(
    parameter int ELEM_WIDTH = 16,
    parameter int CAPACITY   = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    gse_in_if.sink    feed,
    gse_out_if.source drain
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        LOAD,
        EMIT
    } phase_t;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;

    logic                accept_in;
    logic                accept_out;
    logic                full;
    gse_pkg::cell_ctrl_t ctrl;
    logic [ELEM_WIDTH-1:0] new_val;

    logic [ELEM_WIDTH-1:0] cell_val  [CAPACITY];
    logic                  cell_less [CAPACITY];

    assign accept_in  = feed.valid && feed.ready;
    assign accept_out = drain.valid && drain.ready;
    assign full       = (count_reg == CW'(CAPACITY));
    assign new_val    = feed.elem_value[ELEM_WIDTH-1:0];

    assign ctrl.insert    = accept_in && !full;
    assign ctrl.shift_out = accept_out;

    assign feed.ready         = (phase_reg == LOAD);
    assign drain.valid        = (phase_reg == EMIT);
    assign drain.sorted_value = gse_pkg::DATA_W'(cell_val[0]);
    assign drain.last_out     = (count_reg == CW'(1));

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                  occ;
            logic                  left_less;
            logic [ELEM_WIDTH-1:0] left_val;
            logic [ELEM_WIDTH-1:0] right_val;

            assign occ = (CW'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign left_less = 1'b0;
                assign left_val  = '0;
            end
            else
            begin : g_inner
                assign left_less = cell_less[i-1];
                assign left_val  = cell_val[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_val = '0;
            end
            else
            begin : g_body
                assign right_val = cell_val[i+1];
            end

            gse_cell #(
                .W (ELEM_WIDTH)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .new_val   (new_val),
                .occ_self  (occ),
                .left_less (left_less),
                .left_val  (left_val),
                .right_val (right_val),
                .less      (cell_less[i]),
                .val       (cell_val[i])
            );
        end
    endgenerate

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        case (phase_reg)
            LOAD:
            begin
                if (accept_in)
                begin
                    if (!full)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (feed.is_final)
                    begin
                        phase_next = EMIT;
                    end
                end
            end
            EMIT:
            begin
                if (accept_out)
                begin
                    if (count_reg == CW'(1))
                    begin
                        phase_next = LOAD;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                phase_next = LOAD;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= LOAD;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/gse_checker.sv @@
// ----------------------------------------------------------------------------
// gse_checker
// port-level checks on the gnome sort engine, bound to the top level
// ----------------------------------------------------------------------------
module gse_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       feed_valid,
    input logic                       feed_ready,
    input logic                       feed_is_final,
    input logic                       drain_valid,
    input logic                       drain_ready,
    input logic [gse_pkg::DATA_W-1:0] drain_value,
    input logic                       drain_last
);

    // no loading while a set drains
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        feed_ready |-> !drain_valid)
        else $error("feed ready while draining");

    a_final_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (feed_valid && feed_ready && feed_is_final) |=> drain_valid)
        else $error("final item did not start drain");

    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_valid && drain_ready && drain_last) |=> (!drain_valid && feed_ready))
        else $error("drain did not end after last item");

    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_valid && drain_ready && !drain_last)
            |=> (drain_valid && (drain_value >= $past(drain_value))))
        else $error("drained items out of order");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_valid && !drain_ready) |=> (drain_valid && $stable(drain_value)))
        else $error("stalled item changed");

endmodule

bind gnome_sort_engine gse_checker u_gse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .feed_valid    (feed.valid),
    .feed_ready    (feed.ready),
    .feed_is_final (feed.is_final),
    .drain_valid   (drain.valid),
    .drain_ready   (drain.ready),
    .drain_value   (drain.sorted_value),
    .drain_last    (drain.last_out)
);

@@ sim/gse_checker.sv @@
// ----------------------------------------------------------------------------
// gse_scoreboard
// watches the feed and drain channels of the gnome sort engine, keeps its own
// copy of the element store, sorts each completed set by neighbour exchange
// and compares every drained item against the oldest predicted one
// ----------------------------------------------------------------------------
module gse_scoreboard #(
    parameter int ELEM_WIDTH = 16,
    parameter int CAPACITY   = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       feed_valid,
    input  logic                       feed_ready,
    input  logic [gse_pkg::DATA_W-1:0] feed_value,
    input  logic                       feed_final,
    input  logic                       drain_valid,
    input  logic                       drain_ready,
    input  logic [gse_pkg::DATA_W-1:0] drain_value,
    input  logic                       drain_last,
    output int unsigned                fail_count,
    output int unsigned                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [gse_pkg::DATA_W-1:0] value;
        logic                       last;
    } sorted_item_t;

    logic [gse_pkg::DATA_W-1:0] held_elems [CAPACITY];
    int unsigned                held_count;
    sorted_item_t               sorted_q [$];

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        int unsigned                pos;
        logic [gse_pkg::DATA_W-1:0] elem;
        sorted_item_t               want;
        if (!rst_n)
        begin
            held_count = 0;
            fail_count = 0;
            sorted_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (drain_valid && drain_ready)
            begin
                if (sorted_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected item value %h last %b", $time,
                             drain_value, drain_last);
                end
                else
                begin
                    want = sorted_q.pop_front();
                    if (drain_value !== want.value)
                    begin
                        fail_count++;
                        $display("%0t: sorted_value expected %h actual %h", $time,
                                 want.value, drain_value);
                    end
                    if (drain_last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: last_out expected %b actual %b", $time,
                                 want.last, drain_last);
                    end
                end
            end
            if (feed_valid && feed_ready)
            begin
                elem = '0;
                elem[ELEM_WIDTH-1:0] = feed_value[ELEM_WIDTH-1:0];
                // store full: the element is dropped
                if (held_count < CAPACITY)
                begin
                    held_elems[held_count] = elem;
                    held_count++;
                end
                if (feed_final)
                begin
                    pos = 0;
                    while (pos + 1 < held_count)
                    begin
                        if (held_elems[pos] > held_elems[pos+1])
                        begin
                            elem = held_elems[pos];
                            held_elems[pos] = held_elems[pos+1];
                            held_elems[pos+1] = elem;
                            if (pos != 0)
                                pos--;
                            else
                                pos++;
                        end
                        else
                            pos++;
                    end
                    for (int unsigned k = 0; k < held_count; k++)
                    begin
                        want.value = held_elems[k];
                        want.last  = (k + 1 == held_count);
                        sorted_q.push_back(want);
                    end
                    held_count = 0;
                end
            end
            outstanding <= sorted_q.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// feeds sets of elements to the gnome sort engine, a directed group first and
// then random sets under changing idle patterns, with a long drain stall and
// pauses until the engine is empty; the checker judges every sorted item
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ELEM_WIDTH  = 16;
    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 70;
    localparam int HOLD_AFTER  = 60;
    localparam int HOLD_CYCLES = 400;

    typedef enum int unsigned {
        VALS_RANDOM,
        VALS_FEW,
        VALS_EXTREME,
        VALS_RISING,
        VALS_FALLING
    } value_style_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned feed_idle_pct;
    int unsigned drain_idle_pct;
    int unsigned items_sent;
    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned outstanding;

    gse_in_if  feed_if ();
    gse_out_if drain_if ();

    gnome_sort_engine #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .CAPACITY   (CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .feed  (feed_if),
        .drain (drain_if)
    );

    gse_scoreboard #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .CAPACITY   (CAPACITY)
    ) checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .feed_valid  (feed_if.valid),
        .feed_ready  (feed_if.ready),
        .feed_value  (feed_if.elem_value),
        .feed_final  (feed_if.is_final),
        .drain_valid (drain_if.valid),
        .drain_ready (drain_if.ready),
        .drain_value (drain_if.sorted_value),
        .drain_last  (drain_if.last_out),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_item(input logic [gse_pkg::DATA_W-1:0] value,
                             input logic final_flag);
        if ($urandom_range(99) < feed_idle_pct)
        begin
            feed_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < feed_idle_pct);
        end
        feed_if.valid      <= 1'b1;
        feed_if.elem_value <= value;
        feed_if.is_final   <= final_flag;
        do
            @(posedge clk);
        while (!feed_if.ready);
        items_sent++;
    endtask

    task automatic send_set(input int unsigned count, input value_style_t style);
        logic [gse_pkg::DATA_W-1:0] base;
        logic [gse_pkg::DATA_W-1:0] value;
        base = gse_pkg::DATA_W'($urandom);
        for (int unsigned k = 0; k < count; k++)
        begin
            case (style)
                VALS_RANDOM:  value = gse_pkg::DATA_W'($urandom);
                VALS_FEW:     value = gse_pkg::DATA_W'($urandom_range(3));
                VALS_EXTREME:
                    case ($urandom_range(3))
                        0:       value = '0;
                        1:       value = '1;
                        2:       value = gse_pkg::DATA_W'(1);
                        default: value = '1 - gse_pkg::DATA_W'(1);
                    endcase
                VALS_RISING:  value = base + gse_pkg::DATA_W'(k);
                default:      value = base - gse_pkg::DATA_W'(k);
            endcase
            send_item(value, k + 1 == count);
        end
    endtask

    task automatic wait_drained();
        feed_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // drain side: random stalls plus one long hold so the engine backs up
    initial
    begin : drain_side
        int unsigned taken;
        int unsigned hold_left;
        bit          held_once;
        taken     = 0;
        hold_left = 0;
        held_once = 1'b0;
        drain_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (drain_if.valid && drain_if.ready)
                taken++;
            if (!held_once && taken >= HOLD_AFTER)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                drain_if.ready <= 1'b0;
            end
            else
                drain_if.ready <= ($urandom_range(99) >= drain_idle_pct);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned  len;
        value_style_t style;
        rst_n              <= 1'b0;
        feed_if.valid      <= 1'b0;
        feed_if.elem_value <= '0;
        feed_if.is_final   <= 1'b0;
        feed_idle_pct  = 0;
        drain_idle_pct = 0;
        items_sent     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-element sets at both extremes
        send_item(16'hFFFF, 1'b1);
        send_item(16'h0000, 1'b1);
        // mixed extremes
        send_item(16'hFFFF, 1'b0); send_item(16'h0000, 1'b0); send_item(16'h8000, 1'b0);
        send_item(16'h0001, 1'b0); send_item(16'h7FFF, 1'b1);
        // already ascending
        send_item(16'h0001, 1'b0); send_item(16'h0002, 1'b0); send_item(16'h0003, 1'b0);
        send_item(16'h0004, 1'b1);
        // strictly descending
        send_item(16'hFFFF, 1'b0); send_item(16'hFFFE, 1'b0); send_item(16'h0100, 1'b0);
        send_item(16'h0000, 1'b1);
        // duplicates
        send_item(16'h0005, 1'b0); send_item(16'h0005, 1'b0); send_item(16'h0005, 1'b0);
        send_item(16'h0000, 1'b0); send_item(16'h0005, 1'b1);
        // two-element sets, swapped and in order
        send_item(16'h0002, 1'b0); send_item(16'h0001, 1'b1);
        send_item(16'h0001, 1'b0); send_item(16'h0002, 1'b1);
        wait_drained();

        for (int unsigned phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    feed_idle_pct  = 26;
                    drain_idle_pct = 54;
                end
                1:
                begin
                    feed_idle_pct  = 54;
                    drain_idle_pct = 26;
                end
                default:
                begin
                    feed_idle_pct  = 0;
                    drain_idle_pct = 0;
                end
            endcase
            items_sent = 0;
            // overflow: more elements than the store holds
            if (phase == 2)
                send_set(CAPACITY + 4, VALS_RANDOM);
            while (items_sent < PHASE_ITEMS)
            begin
                if ($urandom_range(11) == 0)
                    len = $urandom_range(CAPACITY + 6, CAPACITY - 4);
                else
                    len = $urandom_range(8, 1);
                style = value_style_t'($urandom_range(VALS_FALLING));
                send_set(len, style);
            end
            wait_drained();
        end

        repeat (2 * CAPACITY + 8) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
